FILE: sv/square_waypoint_heading_controller_macros.svh
// ----------------------------------------------------------------------------
// Square waypoint heading controller: assertion macros
// Shared concurrent assertion forms, clocked and gated by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_WAYPOINT_HEADING_CONTROLLER_MACROS_SVH
`define SQUARE_WAYPOINT_HEADING_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWHC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWHC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/swhc_pkg.sv
// ----------------------------------------------------------------------------
// Square waypoint heading controller: package
// Field widths, register indexes, reset values, CORDIC angle table, states.
// ----------------------------------------------------------------------------
`default_nettype none

package swhc_pkg;

    // Field widths
    localparam int COORD_W = 12;
    localparam int ANGLE_W = 15;
    localparam int RATE_W  = 14;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int D2_W    = SQ_W + 1;
    localparam int CFG_W   = 14;
    localparam int IDX_W   = 3;

    // CORDIC datapath
    localparam int ATAN_ITERATIONS = 16;
    localparam int ANG_TABLE_LEN   = 24;
    localparam int ITER_W          = $clog2(ANG_TABLE_LEN);
    localparam int VEC_W           = 24;
    localparam int Z_W             = 20;
    localparam int ERR_W           = 16;

    localparam logic signed [Z_W-1:0]   HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ERR_W-1:0] PI_Q12      = 16'sd12868;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q12  = 16'sd25736;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CORNER_LOW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_CORNER_HIGH  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ARRIVE_RAD   = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEADING_TOL  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_SPEED  = 3'd4;
    localparam logic [IDX_W-1:0] REG_TURN_RATE    = 3'd5;

    // Register reset values
    localparam logic [COORD_W-1:0] RST_CORNER_LOW  = 12'd256;
    localparam logic [COORD_W-1:0] RST_CORNER_HIGH = 12'd2304;
    localparam logic [COORD_W-1:0] RST_ARRIVE_RAD  = 12'd26;
    localparam logic [RATE_W-1:0]  RST_HEADING_TOL = 14'd410;
    localparam logic [COORD_W-1:0] RST_DRIVE_SPEED = 12'd512;
    localparam logic [RATE_W-1:0]  RST_TURN_RATE   = 14'd2048;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_R,
        ST_CHECK,
        ST_ROTATE,
        ST_ERROR,
        ST_DONE
    } swhc_state_t;

    // arctan(2^-i) in Q16 radians, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 20'sd51472;
            5'd1:    val = 20'sd30386;
            5'd2:    val = 20'sd16055;
            5'd3:    val = 20'sd8150;
            5'd4:    val = 20'sd4091;
            5'd5:    val = 20'sd2047;
            5'd6:    val = 20'sd1024;
            5'd7:    val = 20'sd512;
            5'd8:    val = 20'sd256;
            5'd9:    val = 20'sd128;
            5'd10:   val = 20'sd64;
            5'd11:   val = 20'sd32;
            5'd12:   val = 20'sd16;
            5'd13:   val = 20'sd8;
            5'd14:   val = 20'sd4;
            5'd15:   val = 20'sd2;
            5'd16:   val = 20'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: sv/square_waypoint_heading_controller.sv
// ----------------------------------------------------------------------------
// Square waypoint heading controller
// Sequence: squaring pass, arrival check, then, unless the corner is reached,
// the 16 CORDIC iterations on one shared shift-add unit and the heading error step.
// Takes a new pose only after the previous result is loaded into the output register.
// Reset: registers to defaults, corner index to 0, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "square_waypoint_heading_controller_macros.svh"

module square_waypoint_heading_controller (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [swhc_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [swhc_pkg::CFG_W-1:0]          cfg_wdata,
    // pose input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [swhc_pkg::COORD_W-1:0]        s_pos_x,
    input  wire logic [swhc_pkg::COORD_W-1:0]        s_pos_y,
    input  wire logic signed [swhc_pkg::ANGLE_W-1:0] s_heading,
    // command output
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [swhc_pkg::COORD_W-1:0]             m_linear_speed,
    output logic signed [swhc_pkg::ANGLE_W-1:0]      m_angular_speed,
    output logic                                     m_arrived,
    output logic [1:0]                               m_target_corner
);
    import swhc_pkg::*;

    // configuration registers
    logic [COORD_W-1:0] corner_low_reg;
    logic [COORD_W-1:0] corner_high_reg;
    logic [COORD_W-1:0] arrive_radius_reg;
    logic [RATE_W-1:0]  heading_tol_reg;
    logic [COORD_W-1:0] drive_speed_reg;
    logic [RATE_W-1:0]  turn_rate_reg;

    // control
    swhc_state_t        state_reg, state_next;
    logic [1:0]         corner_ptr_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic               out_load;
    logic               m_valid_reg;

    // datapath
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [ANGLE_W-1:0] hd_reg;
    logic [D2_W-1:0]           d2_reg;
    logic [SQ_W-1:0]           r2_reg;
    logic signed [VEC_W-1:0]   x_reg, y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic [COORD_W-1:0]        res_lin_reg;
    logic signed [ANGLE_W-1:0] res_ang_reg;
    logic                      res_arr_reg;

    logic [COORD_W-1:0] m_lin_reg;
    logic signed [ANGLE_W-1:0] m_ang_reg;
    logic               m_arr_reg;
    logic [1:0]         m_corner_reg;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_low_reg    <= RST_CORNER_LOW;
            corner_high_reg   <= RST_CORNER_HIGH;
            arrive_radius_reg <= RST_ARRIVE_RAD;
            heading_tol_reg   <= RST_HEADING_TOL;
            drive_speed_reg   <= RST_DRIVE_SPEED;
            turn_rate_reg     <= RST_TURN_RATE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CORNER_LOW:  corner_low_reg    <= cfg_wdata[COORD_W-1:0];
                REG_CORNER_HIGH: corner_high_reg   <= cfg_wdata[COORD_W-1:0];
                REG_ARRIVE_RAD:  arrive_radius_reg <= cfg_wdata[COORD_W-1:0];
                REG_HEADING_TOL: heading_tol_reg   <= cfg_wdata[RATE_W-1:0];
                REG_DRIVE_SPEED: drive_speed_reg   <= cfg_wdata[COORD_W-1:0];
                REG_TURN_RATE:   turn_rate_reg     <= cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // target corner and offsets
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]       tgt_x, tgt_y;
    logic signed [DIFF_W-1:0] dx_in, dy_in;

    always_comb begin
        tgt_x = (corner_ptr_reg == 2'd1 || corner_ptr_reg == 2'd2) ?
                corner_high_reg : corner_low_reg;
        tgt_y = corner_ptr_reg[1] ? corner_high_reg : corner_low_reg;
        dx_in = $signed({1'b0, tgt_x}) - $signed({1'b0, s_pos_x});
        dy_in = $signed({1'b0, tgt_y}) - $signed({1'b0, s_pos_y});
    end

    // ------------------------------------------------------------------
    // shared squaring multiplier
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0]   mul_op;
    logic signed [2*DIFF_W-1:0] mul_prod;
    logic [SQ_W-1:0]            sq;

    always_comb begin
        case (state_reg)
            ST_SQ_X: mul_op = dx_reg;
            ST_SQ_Y: mul_op = dy_reg;
            default: mul_op = $signed({1'b0, arrive_radius_reg});
        endcase
        mul_prod = mul_op * mul_op;
        sq       = mul_prod[SQ_W-1:0];
    end

    logic arrive;
    logic on_target;
    assign arrive    = d2_reg < {1'b0, r2_reg};
    assign on_target = (dx_reg == '0) && (dy_reg == '0);

    // ------------------------------------------------------------------
    // CORDIC vectoring step and quadrant pre-rotation
    // ------------------------------------------------------------------
    logic signed [VEC_W-1:0] x0, y0, xs, ys, x_step, y_step;
    logic signed [Z_W-1:0]   z_step;

    always_comb begin
        x0 = {{(VEC_W-DIFF_W-8){dx_reg[DIFF_W-1]}}, dx_reg, 8'b0};
        y0 = {{(VEC_W-DIFF_W-8){dy_reg[DIFF_W-1]}}, dy_reg, 8'b0};
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        if (!y_reg[VEC_W-1]) begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + atan_q16(iter_reg);
        end else begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - atan_q16(iter_reg);
        end
    end

    // ------------------------------------------------------------------
    // bearing rounding, heading error wrap and decision
    // ------------------------------------------------------------------
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [ERR_W-1:0] bear, err_raw, err, err_abs;
    logic                    turn;

    always_comb begin
        z_rnd = z_reg + Z_W'(8);
        bear  = z_rnd[Z_W-1:4];
        if (bear > PI_Q12) begin
            bear = PI_Q12;
        end else if (bear < -PI_Q12) begin
            bear = -PI_Q12;
        end
        err_raw = bear - ERR_W'(hd_reg);
        if (err_raw > PI_Q12) begin
            err = err_raw - TWO_PI_Q12;
        end else if (err_raw < -PI_Q12) begin
            err = err_raw + TWO_PI_Q12;
        end else begin
            err = err_raw;
        end
        err_abs = err[ERR_W-1] ? -err : err;
        turn    = $unsigned(err_abs) > {2'b0, heading_tol_reg};
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SQ_X;
            end
            ST_SQ_X: state_next = ST_SQ_Y;
            ST_SQ_Y: state_next = ST_SQ_R;
            ST_SQ_R: state_next = ST_CHECK;
            ST_CHECK: begin
                if (arrive) begin
                    state_next = ST_DONE;
                end else if (on_target) begin
                    state_next = ST_ERROR;
                end else begin
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                if (iter_reg == ITER_W'(ATAN_ITERATIONS - 1)) state_next = ST_ERROR;
            end
            ST_ERROR: state_next = ST_DONE;
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_ptr_reg <= '0;
            iter_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (state_reg == ST_CHECK && arrive) begin
                corner_ptr_reg <= corner_ptr_reg + 2'd1;
            end
            if (state_reg == ST_ROTATE) begin
                iter_reg <= iter_reg + ITER_W'(1);
            end else begin
                iter_reg <= '0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dx_reg <= dx_in;
                    dy_reg <= dy_in;
                    hd_reg <= s_heading;
                end
            end
            ST_SQ_X: d2_reg <= {1'b0, sq};
            ST_SQ_Y: d2_reg <= d2_reg + {1'b0, sq};
            ST_SQ_R: r2_reg <= sq;
            ST_CHECK: begin
                res_lin_reg <= '0;
                res_ang_reg <= '0;
                res_arr_reg <= arrive;
                if (dx_reg[DIFF_W-1]) begin
                    // move the vector into the right half plane
                    if (!dy_reg[DIFF_W-1]) begin
                        x_reg <= y0;
                        y_reg <= -x0;
                        z_reg <= HALF_PI_Q16;
                    end else begin
                        x_reg <= -y0;
                        y_reg <= x0;
                        z_reg <= -HALF_PI_Q16;
                    end
                end else begin
                    // a pose on the corner lands here and keeps a zero bearing
                    x_reg <= x0;
                    y_reg <= y0;
                    z_reg <= '0;
                end
            end
            ST_ROTATE: begin
                x_reg <= x_step;
                y_reg <= y_step;
                z_reg <= z_step;
            end
            ST_ERROR: begin
                if (turn) begin
                    res_ang_reg <= err[ERR_W-1] ? -$signed({1'b0, turn_rate_reg})
                                                :  $signed({1'b0, turn_rate_reg});
                end else begin
                    res_lin_reg <= drive_speed_reg;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            m_lin_reg    <= res_lin_reg;
            m_ang_reg    <= res_ang_reg;
            m_arr_reg    <= res_arr_reg;
            m_corner_reg <= corner_ptr_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_linear_speed  = m_lin_reg;
    assign m_angular_speed = m_ang_reg;
    assign m_arrived       = m_arr_reg;
    assign m_target_corner = m_corner_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SWHC_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == ST_SQ_X, "pose transfer did not start the squaring pass")
    `SWHC_ASSERT_NEXT(a_corner_advance, aclk, aresetn, state_reg == ST_CHECK && arrive, corner_ptr_reg == 2'($past(corner_ptr_reg) + 2'd1), "corner index did not advance on arrival")
    `SWHC_ASSERT_SAME(a_arrive_stops, aclk, aresetn, m_valid && m_arrived, m_linear_speed == '0 && m_angular_speed == '0, "arrival result carries a motion command")
    `SWHC_ASSERT_SAME(a_drive_or_turn, aclk, aresetn, m_valid && m_linear_speed != '0, m_angular_speed == '0, "result both drives and turns")
    `SWHC_ASSERT_SAME(a_iter_bound, aclk, aresetn, state_reg == ST_ROTATE, iter_reg <= ITER_W'(ATAN_ITERATIONS - 1), "CORDIC iteration count ran past its last step")

endmodule

`default_nettype wire
